// File: hdl/rfm_pkg.sv
// shared types and constants of the reciprocal frequency meter
package rfm_pkg;

  localparam int unsigned CLK_W   = 23;
  localparam int unsigned PRE_W   = 4;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned CFG_W   = 23;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned FREQ_W  = 26;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned NUM_W   = 34;
  localparam int unsigned STEP_W  = 6;

  localparam logic [CLK_W-1:0] CLK_RESET   = 23'd1000000;
  localparam logic [PRE_W-1:0] PRE_RESET   = 4'd8;
  localparam logic [LIM_W-1:0] LIM_RESET   = 16'd500;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};
  localparam logic [AGE_W-1:0] AGE_MAX     = {AGE_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_TIMER_CLOCK = 2'd0;
  localparam logic [IDX_W-1:0] REG_PRESCALE    = 2'd1;
  localparam logic [IDX_W-1:0] REG_STALE_LIMIT = 2'd2;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [STAMP_W-1:0]   capture_stamp;
  } rfm_req_t;

  typedef struct packed {
    logic [FREQ_W-1:0]    freq_value;
    logic                 freq_valid;
    logic                 new_measurement;
  } rfm_res_t;

  typedef struct packed {
    logic accept;
    logic load_num;
    logic div_step;
    logic finish;
    logic load_out;
  } rfm_cmd_t;

  typedef struct packed {
    logic need_div;
  } rfm_sts_t;

endpackage

// File: hdl/rfm_ctrl.sv
// controller state machine: handshakes, divide sequencing, output slot
module rfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rfm_pkg::rfm_sts_t sts_i,
  output rfm_pkg::rfm_cmd_t cmd_o
);
  import rfm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_div) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.load_out = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.load_num = 1'b1;
        step_d  = STEP_W'(NUM_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/rfm_datapath.sv
// measurement state, period accumulation, restoring divider and result register
module rfm_datapath #(
  parameter int unsigned AVG_SAMPLES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rfm_pkg::rfm_cmd_t          cmd_i,
  output rfm_pkg::rfm_sts_t          sts_o,
  input  rfm_pkg::rfm_req_t          req_i,
  input  logic [rfm_pkg::CLK_W-1:0]  timer_clock_hz_i,
  input  logic [rfm_pkg::PRE_W-1:0]  edge_prescale_i,
  input  logic [rfm_pkg::LIM_W-1:0]  stale_limit_ms_i,
  output rfm_pkg::rfm_res_t          res_o
);
  import rfm_pkg::*;

  localparam logic [CNT_W-1:0]        AVG_CNT = CNT_W'(AVG_SAMPLES);
  localparam logic [NUM_W-CLK_W-1:0]  AVG_MUL = (NUM_W - CLK_W)'(AVG_SAMPLES);

  logic [STAMP_W-1:0] prev_q, prev_d;
  logic               have_q, have_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FREQ_W-1:0]  meas_q, meas_d;
  logic [AGE_W-1:0]   age_q, age_d;
  logic [SUM_W-1:0]   den_q;
  logic [SUM_W-1:0]   rem_q;
  logic [NUM_W-1:0]   quo_q;
  rfm_res_t           res_q;

  logic [STAMP_W-1:0] diff;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   cnt_inc;
  logic               is_capture;
  logic               counted;
  logic [SUM_W:0]     rem_shift;
  logic [SUM_W:0]     rem_sub;
  logic               q_bit;
  logic [CLK_W+PRE_W-1:0] clk_pre;
  logic [NUM_W-1:0]   num;
  logic [FREQ_W-1:0]  quo_sat;
  logic               valid;

  assign is_capture = (req_i.req_type == REQ_CAPTURE);
  assign diff       = req_i.capture_stamp - prev_q;
  assign sum_add    = sum_q + SUM_W'(diff);
  assign cnt_inc    = cnt_q + 1'b1;
  assign counted    = is_capture && have_q && (diff != '0);
  assign sts_o.need_div = counted && (cnt_inc == AVG_CNT);

  assign clk_pre = (CLK_W + PRE_W)'(timer_clock_hz_i) * (CLK_W + PRE_W)'(edge_prescale_i);
  assign num     = NUM_W'(clk_pre) * NUM_W'(AVG_MUL);

  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign q_bit     = !rem_sub[SUM_W];

  assign quo_sat = (den_q == '0) ? '0 :
                   (quo_q[NUM_W-1:FREQ_W] != '0) ? FREQ_MAX : quo_q[FREQ_W-1:0];

  always_comb begin
    prev_d = prev_q;
    have_d = have_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    meas_d = meas_q;
    age_d  = age_q;
    if (cmd_i.accept) begin
      if (!is_capture) begin
        if (age_q != AGE_MAX) begin
          age_d = age_q + 1'b1;
        end
      end else begin
        prev_d = req_i.capture_stamp;
        have_d = 1'b1;
        if (counted) begin
          if (sts_o.need_div) begin
            sum_d = '0;
            cnt_d = '0;
            age_d = '0;
          end else begin
            sum_d = sum_add;
            cnt_d = cnt_inc;
          end
        end
      end
    end
    if (cmd_i.finish) begin
      meas_d = quo_sat;
    end
  end

  assign valid = (meas_d != '0) && (age_d <= stale_limit_ms_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      have_q <= 1'b0;
      sum_q  <= '0;
      cnt_q  <= '0;
      meas_q <= '0;
      age_q  <= '0;
    end else begin
      prev_q <= prev_d;
      have_q <= have_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      meas_q <= meas_d;
      age_q  <= age_d;
    end
  end

  // divider operands and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.need_div) begin
      den_q <= sum_add;
    end
    if (cmd_i.load_num) begin
      quo_q <= num;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[SUM_W-1:0] : rem_shift[SUM_W-1:0];
    end
    if (cmd_i.load_out) begin
      res_q.freq_value      <= valid ? meas_d : '0;
      res_q.freq_valid      <= valid;
      res_q.new_measurement <= cmd_i.finish;
    end
  end

  assign res_o = res_q;

endmodule

// File: hdl/reciprocal_frequency_meter.sv
// top level of the reciprocal frequency meter: configuration registers and wiring
//
// channel  direction  handshake                payload
// in       input      in_valid_i / in_stall_o  rfm_req_t (req_type, capture_stamp)
// out      output     out_valid_o / out_stall_i rfm_res_t (freq_value, freq_valid,
//                                              new_measurement)
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// ticks and captures that do not close a window give their result in the cycle after
// the transaction; a capture that closes a window first loads the divider operands,
// then runs 34 steps of the radix-2 divider, then stores the quotient and loads the
// output register together, once the output register is free
// one transaction at a time; in_stall_o is high while a divide runs or while a
// stalled result still holds the output register
// reset is asynchronous and clears the control state and the measurement state
module reciprocal_frequency_meter #(
  parameter int unsigned AVG_SAMPLES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rfm_pkg::rfm_req_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rfm_pkg::rfm_res_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [rfm_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [rfm_pkg::CFG_W-1:0] cfg_data_i
);
  import rfm_pkg::*;

  logic [CLK_W-1:0] clk_hz_q;
  logic [PRE_W-1:0] prescale_q;
  logic [LIM_W-1:0] limit_q;
  rfm_cmd_t         cmd;
  rfm_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q   <= CLK_RESET;
      prescale_q <= PRE_RESET;
      limit_q    <= LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMER_CLOCK: clk_hz_q   <= cfg_data_i[CLK_W-1:0];
        REG_PRESCALE:    prescale_q <= cfg_data_i[PRE_W-1:0];
        REG_STALE_LIMIT: limit_q    <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rfm_datapath #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_i            (in_data_i),
    .timer_clock_hz_i (clk_hz_q),
    .edge_prescale_i  (prescale_q),
    .stale_limit_ms_i (limit_q),
    .res_o            (out_data_o)
  );

endmodule

// File: verif/testbench.sv
// testbench for the reciprocal frequency meter: scripted and random transactions, predictor check
`timescale 1ns / 100ps

module testbench;
  import rfm_pkg::*;

  localparam int unsigned AVG_WINDOW = 8;
  localparam int unsigned DOG_LIMIT  = 5000;
  localparam int unsigned SEG_ITEMS  = 108;
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    rfm_req_t         req;
    logic             typed;
    rfm_res_t         want;
  } script_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  rfm_req_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rfm_res_t         out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  reciprocal_frequency_meter #(
    .AVG_SAMPLES(AVG_WINDOW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // meter state mirrored for prediction
  logic [CLK_W-1:0]   timer_hz   = CLK_RESET;
  logic [PRE_W-1:0]   prescale   = PRE_RESET;
  logic [LIM_W-1:0]   stale_ms   = LIM_RESET;
  logic [STAMP_W-1:0] last_stamp = '0;
  logic               stamp_seen = 1'b0;
  logic [SUM_W-1:0]   period_acc = '0;
  logic [CNT_W-1:0]   period_cnt = '0;
  logic [FREQ_W-1:0]  held_freq  = '0;
  logic [AGE_W-1:0]   age_count  = '0;

  rfm_res_t    readings_due[$];
  script_row_t script [0:28];
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic rfm_res_t compute_reading(input rfm_req_t req);
    logic [STAMP_W-1:0] delta;
    logic [63:0]        num;
    logic [63:0]        quot;
    logic               fresh;
    rfm_res_t           r;
    fresh = 1'b0;
    if (req.req_type == REQ_TICK) begin
      if (age_count != AGE_MAX) age_count = age_count + 1'b1;
    end else if (!stamp_seen) begin
      last_stamp = req.capture_stamp;
      stamp_seen = 1'b1;
    end else begin
      delta = req.capture_stamp - last_stamp;
      last_stamp = req.capture_stamp;
      if (delta != '0) begin
        period_acc = period_acc + delta;
        period_cnt = period_cnt + 1'b1;
        if (period_cnt >= AVG_WINDOW) begin
          num = 64'(timer_hz) * 64'(prescale) * 64'(AVG_WINDOW);
          quot = (period_acc != '0) ? num / 64'(period_acc) : 64'd0;
          held_freq = (quot > 64'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
          period_acc = '0;
          period_cnt = '0;
          age_count = '0;
          fresh = 1'b1;
        end
      end
    end
    r.freq_valid = (held_freq != '0) && (age_count <= stale_ms);
    r.freq_value = r.freq_valid ? held_freq : '0;
    r.new_measurement = fresh;
    return r;
  endfunction

  function automatic script_row_t req_row(input logic rtype, input logic [STAMP_W-1:0] stamp,
                                          input logic typed, input logic [FREQ_W-1:0] freq,
                                          input logic valid, input logic fresh);
    script_row_t row;
    row.kind = ROW_REQ;
    row.idx = REG_NONE;
    row.data = '0;
    row.req.req_type = rtype;
    row.req.capture_stamp = stamp;
    row.typed = typed;
    row.want.freq_value = freq;
    row.want.freq_valid = valid;
    row.want.new_measurement = fresh;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    script_row_t row;
    row = req_row(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // called at a rising edge; leaves valid high so the next call can follow without a gap
  task automatic send_req(input rfm_req_t req, input logic typed, input rfm_res_t want);
    rfm_res_t predicted;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    predicted = compute_reading(req);
    readings_due.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TIMER_CLOCK: timer_hz = data;
      REG_PRESCALE:    prescale = data[PRE_W-1:0];
      REG_STALE_LIMIT: stale_ms = data[LIM_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // results are compared mid-cycle, ahead of the edge that takes them
  always @(negedge clk_i) begin
    rfm_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readings_due.size() == 0) begin
        flag_error($sformatf("unexpected result: freq %0d valid %0b new %0b",
                             out_data_o.freq_value, out_data_o.freq_valid,
                             out_data_o.new_measurement));
      end else begin
        want = readings_due.pop_front();
        if (out_data_o.freq_value !== want.freq_value ||
            out_data_o.freq_valid !== want.freq_valid ||
            out_data_o.new_measurement !== want.new_measurement) begin
          flag_error($sformatf(
            "mismatch: expected freq %0d valid %0b new %0b, got freq %0d valid %0b new %0b",
            want.freq_value, want.freq_valid, want.new_measurement,
            out_data_o.freq_value, out_data_o.freq_valid, out_data_o.new_measurement));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= DOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int                 sel;
    int                 roll;
    int                 tick_pct;
    logic [STAMP_W-1:0] cur_stamp;
    logic [STAMP_W-1:0] period;
    logic [CLK_W-1:0]   clk_val;
    logic [PRE_W-1:0]   pre_val;
    logic [LIM_W-1:0]   lim_val;
    rfm_req_t           req;

    script = '{
      req_row(REQ_TICK,    16'h0000, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'hFFFF, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'hFFFF, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd999,  1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd1999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd2999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_TICK,    16'hFFFF, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd3999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd4999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd5999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd6999, 1'b1, 26'd0,    1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd7999, 1'b1, 26'd8000, 1'b1, 1'b1),
      req_row(REQ_TICK,    16'h0000, 1'b1, 26'd8000, 1'b1, 1'b0),
      req_row(REQ_CAPTURE, 16'd7999, 1'b1, 26'd8000, 1'b1, 1'b0),
      cfg_row(REG_STALE_LIMIT, 23'd1),
      req_row(REQ_TICK,    16'h0000, 1'b1, 26'd0,    1'b0, 1'b0),
      cfg_row(REG_STALE_LIMIT, 23'h7FFFFF),
      req_row(REQ_TICK,    16'h0000, 1'b1, 26'd8000, 1'b1, 1'b0),
      cfg_row(REG_TIMER_CLOCK, 23'd8000000),
      cfg_row(REG_PRESCALE, 23'h7FFFFF),
      cfg_row(REG_NONE, 23'h000000),
      req_row(REQ_CAPTURE, 16'd8000, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8001, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8002, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8003, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8004, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8005, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8006, 1'b0, '0, 1'b0, 1'b0),
      req_row(REQ_CAPTURE, 16'd8007, 1'b1, FREQ_MAX, 1'b1, 1'b1)
    };

    in_gap_pct = 11;
    out_stall_pct = 80;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_req(script[i].req, script[i].typed, script[i].want);
      end
    end

    cur_stamp = 16'd8007;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin in_gap_pct = 11; out_stall_pct = 80; end
        1: begin in_gap_pct = 80; out_stall_pct = 11; end
        default: begin in_gap_pct = 0; out_stall_pct = 0; end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        sel = ph * 6 + seg;
        case (sel % 6)
          0: clk_val = '0;
          1: clk_val = 23'd1;
          2: clk_val = 23'd8000000;
          3: clk_val = '1;
          default: clk_val = 23'($urandom_range(1, 8000000));
        endcase
        case (sel % 5)
          0: pre_val = 4'd0;
          1: pre_val = 4'd1;
          2: pre_val = 4'd8;
          3: pre_val = 4'd15;
          default: pre_val = 4'($urandom_range(0, 15));
        endcase
        case (sel % 8)
          0: lim_val = 16'd0;
          1: lim_val = 16'd1;
          2: lim_val = 16'd65534;
          3: lim_val = 16'd65535;
          7: lim_val = 16'($urandom());
          default: lim_val = 16'($urandom_range(0, 40));
        endcase
        case ($urandom_range(3))
          0: period = 16'($urandom_range(1, 8));
          1: period = 16'($urandom_range(9, 1000));
          2: period = 16'($urandom_range(1001, 8191));
          default: period = 16'($urandom_range(8192, 65535));
        endcase
        case ($urandom_range(2))
          0: tick_pct = 5;
          1: tick_pct = 30;
          default: tick_pct = 60;
        endcase

        wait_drained();
        write_reg(REG_TIMER_CLOCK, clk_val);
        write_reg(REG_PRESCALE, {19'($urandom()), pre_val});
        write_reg(REG_STALE_LIMIT, {7'($urandom()), lim_val});
        if ($urandom_range(3) == 0) write_reg(REG_NONE, 23'($urandom()));

        for (int k = 0; k < SEG_ITEMS; k++) begin
          roll = $urandom_range(99);
          req.capture_stamp = 16'($urandom());
          if (roll < tick_pct) begin
            req.req_type = REQ_TICK;
          end else begin
            req.req_type = REQ_CAPTURE;
            if (roll < tick_pct + 5) begin
              req.capture_stamp = cur_stamp;
            end else if (roll < 95) begin
              req.capture_stamp = cur_stamp + period + 16'($urandom_range(0, 2));
            end
            cur_stamp = req.capture_stamp;
          end
          send_req(req, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rfm_pkg.sv
hdl/rfm_ctrl.sv
hdl/rfm_datapath.sv
hdl/reciprocal_frequency_meter.sv
verif/testbench.sv
